/* rtl/two_table_cuckoo_hash_macros.svh */
// Assertion helpers for the cuckoo hash block
`ifndef TWO_TABLE_CUCKOO_HASH_MACROS_SVH
`define TWO_TABLE_CUCKOO_HASH_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define TTCH_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define TTCH_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ttch_pkg.sv */
`default_nettype none
package ttch_pkg;
    localparam int FIRST_DEPTH_DEF  = 32;
    localparam int SECOND_DEPTH_DEF = 32;
    localparam int MAX_PATH_DEF     = 64;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Datapath commands
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_LOAD      = 4'd1;  // latch item
    localparam logic [3:0] CMD_HASH      = 4'd2;  // advance hash pipeline one stage
    localparam logic [3:0] CMD_PROBE     = 4'd3;  // read both home slots
    localparam logic [3:0] CMD_APPLY     = 4'd4;  // perform the simple operation
    localparam logic [3:0] CMD_WREAD     = 4'd5;  // read current walk slot
    localparam logic [3:0] CMD_WSTEP     = 4'd6;  // record path, hash the resident
    localparam logic [3:0] CMD_SREAD     = 4'd7;  // read path entry for shift
    localparam logic [3:0] CMD_SFETCH    = 4'd8;  // read source entry
    localparam logic [3:0] CMD_SMOVE     = 4'd9;  // move entry forward
    localparam logic [3:0] CMD_FINAL     = 4'd10; // place new key in first table
    localparam logic [3:0] CMD_FULL      = 4'd11; // report full

    typedef struct packed {
        logic [3:0] cmd;
    } t_ctl;

    typedef struct packed {
        logic need_walk;  // insert found key absent and both home slots occupied
        logic walk_empty; // current walk slot empty
        logic walk_limit; // walk depth reached the limit
        logic path_done;  // shift reached the start
        logic hash_done;  // hash pipeline finished
    } t_sts;

    function automatic logic [31:0] sar(input logic [31:0] x, input int n);
        sar = 32'($signed(x) >>> n);
    endfunction
endpackage
`default_nettype wire

/* rtl/two_table_cuckoo_hash.sv */
`default_nettype none
// Two-table cuckoo hash map, 32-bit keys to 32-bit values. Pulse start with
// opcode, key and value_in while busy is low; busy rises the next cycle and
// the result appears on o_status/o_value_out for exactly one cycle with
// o_valid high. The receiver cannot stall, so capture it then. Lookup, delete
// and simple insert hash the key, probe both home slots and apply the
// operation, then present the result in the same cycle that busy falls, so a
// new transaction can be taken once the result appears (each table's hash is
// iterated in its own register, then a registered probe). An eviction insert
// adds a slot read, a check and a rehash per walk step, and a check, a path
// read, a source fetch and a move per shifted entry, up to MAX_PATH steps.
`include "two_table_cuckoo_hash_macros.svh"
module two_table_cuckoo_hash #(
    parameter int FIRST_DEPTH  = ttch_pkg::FIRST_DEPTH_DEF,
    parameter int SECOND_DEPTH = ttch_pkg::SECOND_DEPTH_DEF,
    parameter int MAX_PATH     = ttch_pkg::MAX_PATH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_value_in,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_value_out
);
    import ttch_pkg::*;

    t_ctl ctl;
    t_sts sts;

    ttch_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    ttch_dp #(
        .FIRST_DEPTH  (FIRST_DEPTH),
        .SECOND_DEPTH (SECOND_DEPTH),
        .MAX_PATH     (MAX_PATH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_value_in  (i_value_in),
        .o_sts       (sts),
        .o_done      (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

    // A taken start raises busy, non-OK results carry a zero value, and o_valid never repeats
    `TTCH_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "start not taken")
    `TTCH_ASSERT_IMPL(a_vout_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_value_out == '0, "nonzero value on miss")
    `TTCH_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, o_valid, !o_valid, "result repeated")
endmodule
`default_nettype wire

/* rtl/ttch_ctrl.sv */
`default_nettype none
module ttch_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire ttch_pkg::t_sts i_sts,
    output ttch_pkg::t_ctl     o_ctl,
    output logic               o_busy
);
    import ttch_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_PROBE = 4'd2;
    localparam logic [3:0] S_APPLY = 4'd3;
    localparam logic [3:0] S_WREAD = 4'd4;
    localparam logic [3:0] S_WCHK  = 4'd5;
    localparam logic [3:0] S_WHASH = 4'd6;
    localparam logic [3:0] S_SREAD = 4'd7;
    localparam logic [3:0] S_SFET  = 4'd8;
    localparam logic [3:0] S_SMOVE = 4'd9;
    localparam logic [3:0] S_FINAL = 4'd10;
    localparam logic [3:0] S_FULL  = 4'd11;
    localparam logic [3:0] S_SCHK  = 4'd12;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Sequence commands for the datapath
    always_comb begin
        n_state   = r_state;
        o_ctl.cmd = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_HASH;
                end
            end
            S_HASH: begin
                o_ctl.cmd = CMD_HASH;
                if (i_sts.hash_done) n_state = S_PROBE;
            end
            S_PROBE: begin
                o_ctl.cmd = CMD_PROBE;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                o_ctl.cmd = CMD_APPLY;
                n_state   = i_sts.need_walk ? S_WREAD : S_IDLE;
            end
            S_WREAD: begin
                o_ctl.cmd = CMD_WREAD;
                n_state   = S_WCHK;
            end
            S_WCHK: begin
                // The limit ends the walk before the slot at that depth is looked at
                if (i_sts.walk_limit)      n_state = S_FULL;
                else if (i_sts.walk_empty) n_state = S_SCHK;
                else begin
                    o_ctl.cmd = CMD_WSTEP;
                    n_state   = S_WHASH;
                end
            end
            S_WHASH: begin
                o_ctl.cmd = CMD_HASH;
                if (i_sts.hash_done) n_state = S_WREAD;
            end
            S_SCHK: begin
                n_state = i_sts.path_done ? S_FINAL : S_SREAD;
            end
            S_SREAD: begin
                o_ctl.cmd = CMD_SREAD;
                n_state   = S_SFET;
            end
            S_SFET: begin
                o_ctl.cmd = CMD_SFETCH;
                n_state   = S_SMOVE;
            end
            S_SMOVE: begin
                o_ctl.cmd = CMD_SMOVE;
                n_state   = S_SCHK;
            end
            S_FINAL: begin
                o_ctl.cmd = CMD_FINAL;
                n_state   = S_IDLE;
            end
            S_FULL: begin
                o_ctl.cmd = CMD_FULL;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

/* rtl/ttch_hash.sv */
`default_nettype none
module ttch_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_adv,
    input  wire logic [31:0] i_key,
    output logic [31:0]      o_h1,
    output logic [31:0]      o_h2,
    output logic             o_done
);
    import ttch_pkg::*;

    localparam int LAST = 4;

    logic [31:0] r_a, r_b;
    logic [2:0]  r_step;

    // Iterate both mixing hashes, alternating multiply and xor-shift steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
        end else if (i_start) begin
            r_a    <= (i_key ^ 32'd61) ^ sar(i_key, 16);
            r_b    <= sar(i_key, 16) ^ i_key;
            r_step <= 3'd0;
        end else if (i_adv && r_step != 3'(LAST)) begin
            r_step <= r_step + 3'd1;
            case (r_step)
                3'd0: begin
                    r_a <= r_a * 32'd9;
                    r_b <= r_b * 32'h045d9f3b;
                end
                3'd1: begin
                    r_a <= r_a ^ sar(r_a, 4);
                    r_b <= sar(r_b, 16) ^ r_b;
                end
                3'd2: begin
                    r_a <= r_a * 32'h27d4eb2d;
                    r_b <= r_b * 32'h045d9f3b;
                end
                3'd3: begin
                    r_a <= r_a ^ sar(r_a, 15);
                    r_b <= sar(r_b, 16) ^ r_b;
                end
                default: ;
            endcase
        end
    end

    assign o_h1   = r_a;
    assign o_h2   = r_b;
    assign o_done = (r_step == 3'(LAST));
endmodule
`default_nettype wire

/* rtl/ttch_dp.sv */
`default_nettype none
module ttch_dp #(
    parameter int FIRST_DEPTH  = ttch_pkg::FIRST_DEPTH_DEF,
    parameter int SECOND_DEPTH = ttch_pkg::SECOND_DEPTH_DEF,
    parameter int MAX_PATH     = ttch_pkg::MAX_PATH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ttch_pkg::t_ctl i_ctl,
    input  wire logic [1:0]     i_opcode,
    input  wire logic [31:0]    i_key,
    input  wire logic [31:0]    i_value_in,
    output ttch_pkg::t_sts      o_sts,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic [31:0]         o_value_out
);
    import ttch_pkg::*;

    localparam int AW1 = $clog2(FIRST_DEPTH);
    localparam int AW2 = $clog2(SECOND_DEPTH);
    localparam int AWM = (AW1 > AW2) ? AW1 : AW2;
    localparam int PW  = $clog2(MAX_PATH);
    localparam int DW  = $clog2(MAX_PATH + 1);

    logic [31:0] mem1_k [FIRST_DEPTH];
    logic [31:0] mem1_v [FIRST_DEPTH];
    logic [31:0] mem2_k [SECOND_DEPTH];
    logic [31:0] mem2_v [SECOND_DEPTH];
    logic [AWM-1:0] mem_p [MAX_PATH];
    logic [FIRST_DEPTH-1:0]  r_val1;
    logic [SECOND_DEPTH-1:0] r_val2;

    logic [1:0]     r_op;
    logic [31:0]    r_key, r_vin;
    logic [AW1-1:0] r_h1;
    logic [AW2-1:0] r_h2;
    logic [31:0]    r_rk1, r_rv1, r_rk2, r_rv2;
    logic [AWM-1:0] r_idx, r_src;
    logic           r_tbl;
    logic [DW-1:0]  r_depth;
    logic           r_first_hash;
    logic           r_done;
    logic [1:0]     r_status;
    logic [31:0]    r_vout;

    logic [31:0] hk, h1, h2;
    logic        h_done, h_start;
    logic        in1, in2;
    logic [AW1-1:0] idx1;
    logic [AW2-1:0] idx2;
    logic [AW1-1:0] src1;
    logic [AW2-1:0] src2;

    assign idx1 = r_idx[AW1-1:0];
    assign idx2 = r_idx[AW2-1:0];
    assign src1 = r_src[AW1-1:0];
    assign src2 = r_src[AW2-1:0];

    // Hash either the new key or the resident evicted from the walk slot
    assign h_start = (i_ctl.cmd == CMD_LOAD) || (i_ctl.cmd == CMD_WSTEP);
    assign hk = (i_ctl.cmd == CMD_LOAD) ? i_key : (r_tbl ? r_rk2 : r_rk1);

    ttch_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_adv   (i_ctl.cmd == CMD_HASH),
        .i_key   (hk),
        .o_h1    (h1),
        .o_h2    (h2),
        .o_done  (h_done)
    );

    assign in1 = r_val1[r_h1] && (r_rk1 == r_key);
    assign in2 = r_val2[r_h2] && (r_rk2 == r_key);

    // Memory ports: registered reads, single write per table
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_PROBE: begin
                r_rk1 <= mem1_k[h1[AW1-1:0]];
                r_rv1 <= mem1_v[h1[AW1-1:0]];
                r_rk2 <= mem2_k[h2[AW2-1:0]];
                r_rv2 <= mem2_v[h2[AW2-1:0]];
            end
            CMD_WREAD: begin
                r_rk1 <= mem1_k[idx1];
                r_rk2 <= mem2_k[idx2];
            end
            CMD_SREAD: r_src <= mem_p[r_depth[PW-1:0] - PW'(1)];
            CMD_SFETCH: begin
                r_rk1 <= mem1_k[src1];
                r_rv1 <= mem1_v[src1];
                r_rk2 <= mem2_k[src2];
                r_rv2 <= mem2_v[src2];
            end
            CMD_APPLY: begin
                if (r_op == OP_INSERT) begin
                    if (in1) mem1_v[r_h1] <= r_vin;
                    else if (in2) mem2_v[r_h2] <= r_vin;
                    else if (!r_val1[r_h1]) begin
                        mem1_k[r_h1] <= r_key;
                        mem1_v[r_h1] <= r_vin;
                    end else if (!r_val2[r_h2]) begin
                        mem2_k[r_h2] <= r_key;
                        mem2_v[r_h2] <= r_vin;
                    end
                end
            end
            CMD_WSTEP: mem_p[r_depth[PW-1:0]] <= r_idx;
            CMD_SMOVE: begin
                if (r_tbl) begin
                    mem2_k[idx2] <= r_rk1;
                    mem2_v[idx2] <= r_rv1;
                end else begin
                    mem1_k[idx1] <= r_rk2;
                    mem1_v[idx1] <= r_rv2;
                end
            end
            CMD_FINAL: begin
                mem1_k[r_h1] <= r_key;
                mem1_v[r_h1] <= r_vin;
            end
            default: ;
        endcase
    end

    // Control registers, valid bits and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val1       <= '0;
            r_val2       <= '0;
            r_done       <= 1'b0;
            r_first_hash <= 1'b0;
            r_tbl        <= 1'b0;
            r_depth      <= '0;
        end else begin
            r_done <= 1'b0;
            case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_op         <= i_opcode;
                    r_key        <= i_key;
                    r_vin        <= i_value_in;
                    r_first_hash <= 1'b1;
                end
                CMD_HASH: begin
                    if (h_done && r_first_hash) begin
                        r_h1         <= h1[AW1-1:0];
                        r_h2         <= h2[AW2-1:0];
                        r_first_hash <= 1'b0;
                    end else if (h_done) begin
                        // Resident of first table goes to its second slot
                        r_idx <= r_tbl ? AWM'(h2[AW2-1:0]) : AWM'(h1[AW1-1:0]);
                    end
                end
                CMD_APPLY: begin
                    r_done   <= 1'b1;
                    r_status <= ST_MISS;
                    r_vout   <= '0;
                    r_idx    <= AWM'(r_h1);
                    r_tbl    <= 1'b0;
                    r_depth  <= '0;
                    case (r_op)
                        OP_LOOKUP: begin
                            if (in1) begin
                                r_status <= ST_OK;
                                r_vout   <= r_rv1;
                            end else if (in2) begin
                                r_status <= ST_OK;
                                r_vout   <= r_rv2;
                            end
                        end
                        OP_INSERT: begin
                            r_status <= ST_OK;
                            if (!in1 && !in2) begin
                                if (!r_val1[r_h1]) r_val1[r_h1] <= 1'b1;
                                else if (!r_val2[r_h2]) r_val2[r_h2] <= 1'b1;
                                else r_done <= 1'b0;
                            end
                        end
                        OP_DELETE: begin
                            if (in1) begin
                                r_val1[r_h1] <= 1'b0;
                                r_status     <= ST_OK;
                            end else if (in2) begin
                                r_val2[r_h2] <= 1'b0;
                                r_status     <= ST_OK;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_WSTEP: begin
                    r_depth <= r_depth + DW'(1);
                    r_tbl   <= ~r_tbl;
                end
                CMD_SMOVE: begin
                    if (r_tbl) begin
                        r_val2[idx2] <= 1'b1;
                        r_val1[src1] <= 1'b0;
                    end else begin
                        r_val1[idx1] <= 1'b1;
                        r_val2[src2] <= 1'b0;
                    end
                    r_tbl   <= ~r_tbl;
                    r_idx   <= r_src;
                    r_depth <= r_depth - DW'(1);
                end
                CMD_FINAL: begin
                    r_val1[r_h1] <= 1'b1;
                    r_done       <= 1'b1;
                    r_status     <= ST_OK;
                    r_vout       <= '0;
                end
                CMD_FULL: begin
                    r_done   <= 1'b1;
                    r_status <= ST_FULL;
                    r_vout   <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.need_walk  = (r_op == OP_INSERT) && !in1 && !in2 &&
                              r_val1[r_h1] && r_val2[r_h2];
    assign o_sts.walk_empty = r_tbl ? !r_val2[idx2] : !r_val1[idx1];
    assign o_sts.walk_limit = (r_depth == DW'(MAX_PATH));
    assign o_sts.path_done  = (r_depth == '0);
    assign o_sts.hash_done  = h_done;

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
endmodule
`default_nettype wire
